/* hdl/bpfa_pkg.sv */
// shared types, constants and helpers for the bitmap page frame allocator
`timescale 1ns / 1ps
`default_nettype none

package bpfa_pkg;

    // geometry of the page bitmap
    localparam int MAX_PAGES = 4096;
    localparam int PAGE_W    = 12;
    localparam int CNT_W     = 13;
    localparam int WORD_W    = 64;
    localparam int POS_W     = 6;
    localparam int ROW_W     = PAGE_W - POS_W;
    localparam int ROWS      = MAX_PAGES / WORD_W;
    localparam int LEN_W     = POS_W + 1;
    localparam int CFG_IDX_W = 1;

    localparam logic [CNT_W-1:0] COUNT_MAX     = '1;
    localparam logic [CNT_W-1:0] PAGE_LIMIT    = CNT_W'(MAX_PAGES);
    localparam logic [CNT_W-1:0] RESERVED_INIT = CNT_W'(8);

    // request kinds
    localparam logic FUNC_ALLOC = 1'b0;
    localparam logic FUNC_FREE  = 1'b1;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_MANAGED  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_RESERVED = 1'b1;

    typedef enum logic [1:0] {
        STAT_OK      = 2'd0,
        STAT_NOSPACE = 2'd1,
        STAT_BAD     = 2'd2
    } bpfa_status_t;

    typedef enum logic [2:0] {
        SEQ_IDLE,
        SEQ_START,
        SEQ_SCAN_RD,
        SEQ_SCAN,
        SEQ_GRANT,
        SEQ_MOD_RD,
        SEQ_MOD_WR,
        SEQ_DONE
    } bpfa_state_t;

    typedef logic [WORD_W-1:0] word_t;

    // bitmap read request
    typedef struct packed {
        logic             en;
        logic [ROW_W-1:0] row;
    } map_rd_t;

    // bitmap write request
    typedef struct packed {
        logic             en;
        logic [ROW_W-1:0] row;
        word_t            data;
    } map_wr_t;

    // one step of the segment scanner
    typedef struct packed {
        logic             hit;
        logic             used;
        logic [LEN_W-1:0] len;
    } seg_res_t;

    // index of the lowest set bit, WORD_W when none is set
    function automatic logic [LEN_W-1:0] trail_zeros(input word_t v);
        logic [LEN_W-1:0] r;
        r = LEN_W'(WORD_W);
        for (int i = WORD_W - 1; i >= 0; i--) begin
            if (v[i]) begin
                r = LEN_W'(i);
            end
        end
        return r;
    endfunction

endpackage

`default_nettype wire

/* hdl/bpfa_map.sv */
// page bitmap memory, one row of 64 pages per word, rows read as free until written
`timescale 1ns / 1ps
`default_nettype none

module bpfa_map (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire bpfa_pkg::map_rd_t rd,
    output bpfa_pkg::word_t       rdata,
    input  wire bpfa_pkg::map_wr_t wr
);
    import bpfa_pkg::*;

    word_t            mem [ROWS];
    logic [ROWS-1:0]  valid_reg;
    word_t            rdata_reg;

    // row storage
    always_ff @(posedge aclk) begin
        if (wr.en) begin
            mem[wr.row] <= wr.data;
        end
    end

    // row written marks, cleared by reset so the bitmap starts all free
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (wr.en) begin
            valid_reg[wr.row] <= 1'b1;
        end
    end

    // registered read, unwritten rows read as zero
    always_ff @(posedge aclk) begin
        if (rd.en) begin
            rdata_reg <= valid_reg[rd.row] ? mem[rd.row] : '0;
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

/* hdl/bpfa_seg.sv */
// shared segment unit: length of the same-valued run at a bit position, and run-complete check
`timescale 1ns / 1ps
`default_nettype none

module bpfa_seg (
    input  wire bpfa_pkg::word_t              word,
    input  wire logic [bpfa_pkg::POS_W-1:0]   pos,
    input  wire logic [bpfa_pkg::CNT_W-1:0]   rem,
    input  wire logic [bpfa_pkg::CNT_W-1:0]   run,
    input  wire logic [bpfa_pkg::CNT_W-1:0]   need,
    output bpfa_pkg::seg_res_t                res
);
    import bpfa_pkg::*;

    logic             cur_used;
    word_t            shifted;
    logic [LEN_W-1:0] tz;
    logic [LEN_W-1:0] cap;
    logic [LEN_W-1:0] len_word;
    logic [LEN_W-1:0] len;
    logic [CNT_W-1:0] run_sum;

    // align the current page to bit 0, invert so the run is always zeros
    always_comb begin
        cur_used = word[pos];
        shifted  = (cur_used ? ~word : word) >> pos;
        tz       = trail_zeros(shifted);
        cap      = LEN_W'(WORD_W) - {1'b0, pos};
        len_word = (tz < cap) ? tz : cap;
        len      = (rem < CNT_W'(len_word)) ? rem[LEN_W-1:0] : len_word;
        run_sum  = run + CNT_W'(len);
    end

    // a free segment that brings the run to the requested size is a hit
    always_comb begin
        res.used = cur_used;
        res.len  = len;
        res.hit  = !cur_used && (run_sum >= need);
    end

endmodule

`default_nettype wire

/* hdl/bpfa_seq.sv */
// request sequencer: first-fit scan, bitmap update, counters and result register
`timescale 1ns / 1ps
`default_nettype none

module bpfa_seq (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        s_tvalid,
    output logic                             s_tready,
    input  wire logic                        req_func,
    input  wire logic [bpfa_pkg::PAGE_W-1:0] req_start,
    input  wire logic [bpfa_pkg::CNT_W-1:0]  req_count,
    input  wire logic [bpfa_pkg::CNT_W-1:0]  limit,
    input  wire logic [bpfa_pkg::CNT_W-1:0]  reserved,
    output bpfa_pkg::map_rd_t                map_rd,
    input  wire bpfa_pkg::word_t             map_rdata,
    output bpfa_pkg::map_wr_t                map_wr,
    output logic                             m_tvalid,
    input  wire logic                        m_tready,
    output logic [1:0]                       res_status,
    output logic [bpfa_pkg::PAGE_W-1:0]      res_granted,
    output logic [bpfa_pkg::CNT_W-1:0]       res_used
);
    import bpfa_pkg::*;

    bpfa_state_t      state_reg, state_next;
    logic             func_reg, func_next;
    logic [PAGE_W-1:0] start_reg, start_next;
    logic [CNT_W-1:0] need_reg, need_next;
    logic [CNT_W-1:0] cur_reg, cur_next;
    logic [CNT_W-1:0] run_reg, run_next;
    logic [PAGE_W-1:0] first_reg, first_next;
    logic [PAGE_W-1:0] last_reg, last_next;
    logic [ROW_W-1:0] row_reg, row_next;
    logic             set_reg, set_next;
    logic [PAGE_W-1:0] hint_reg, hint_next;
    logic [CNT_W-1:0] used_reg, used_next;
    bpfa_status_t     rstat_reg, rstat_next;
    logic [PAGE_W-1:0] rgrant_reg, rgrant_next;
    logic [CNT_W-1:0] rused_reg, rused_next;
    logic [PAGE_W-1:0] rhint_reg, rhint_next;
    logic             out_valid_reg, out_valid_next;
    bpfa_status_t     out_status_reg, out_status_next;
    logic [PAGE_W-1:0] out_grant_reg, out_grant_next;
    logic [CNT_W-1:0] out_used_reg, out_used_next;

    seg_res_t         seg;
    logic             at_limit;
    logic             result_load;
    logic [CNT_W-1:0] cur_adv;
    logic [CNT_W:0]   free_sum;
    logic [CNT_W-1:0] free_end;
    logic             free_any;
    logic [CNT_W-1:0] free_cnt;
    logic [CNT_W:0]   alloc_sum;
    logic [PAGE_W-1:0] alloc_last;
    logic [CNT_W-1:0] hint_wide;
    logic [POS_W-1:0] mask_lo;
    logic [POS_W-1:0] mask_hi;
    word_t            mod_mask;

    // shared scan unit working on the current bitmap row
    bpfa_seg u_seg (
        .word (map_rdata),
        .pos  (cur_reg[POS_W-1:0]),
        .rem  (limit - cur_reg),
        .run  (run_reg),
        .need (need_reg),
        .res  (seg)
    );

    // common datapath terms
    always_comb begin
        at_limit    = cur_reg >= limit;
        result_load = !out_valid_reg || m_tready;
        cur_adv     = cur_reg + CNT_W'(seg.len);
        free_sum    = {2'b0, start_reg} + {1'b0, need_reg};
        free_end    = (free_sum > {1'b0, limit}) ? limit : free_sum[CNT_W-1:0];
        free_any    = CNT_W'({1'b0, start_reg}) < free_end;
        free_cnt    = free_any ? (free_end - CNT_W'({1'b0, start_reg})) : '0;
        alloc_sum   = {1'b0, used_reg} + {1'b0, need_reg};
        alloc_last  = first_reg + PAGE_W'(need_reg - CNT_W'(1));
        hint_wide   = CNT_W'({1'b0, hint_reg});
        mask_lo     = (row_reg == first_reg[PAGE_W-1:POS_W]) ? first_reg[POS_W-1:0] : '0;
        mask_hi     = (row_reg == last_reg[PAGE_W-1:POS_W]) ? last_reg[POS_W-1:0] : '1;
        mod_mask    = (word_t'('1) << mask_lo) & (word_t'('1) >> (POS_W'(WORD_W - 1) - mask_hi));
    end

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            SEQ_IDLE: begin
                if (s_tvalid) begin
                    state_next = SEQ_START;
                end
            end
            SEQ_START: begin
                if (need_reg == '0) begin
                    state_next = SEQ_DONE;
                end else if (func_reg == FUNC_ALLOC) begin
                    state_next = SEQ_SCAN_RD;
                end else if (free_any) begin
                    state_next = SEQ_MOD_RD;
                end else begin
                    state_next = SEQ_DONE;
                end
            end
            SEQ_SCAN_RD: begin
                state_next = at_limit ? SEQ_DONE : SEQ_SCAN;
            end
            SEQ_SCAN: begin
                if (at_limit) begin
                    state_next = SEQ_DONE;
                end else if (seg.hit) begin
                    state_next = SEQ_GRANT;
                end else if (cur_adv[POS_W-1:0] == '0) begin
                    state_next = SEQ_SCAN_RD;
                end
            end
            SEQ_GRANT: begin
                state_next = SEQ_MOD_RD;
            end
            SEQ_MOD_RD: begin
                state_next = SEQ_MOD_WR;
            end
            SEQ_MOD_WR: begin
                if (row_reg == last_reg[PAGE_W-1:POS_W]) begin
                    state_next = SEQ_DONE;
                end else begin
                    state_next = SEQ_MOD_RD;
                end
            end
            SEQ_DONE: begin
                if (result_load) begin
                    state_next = SEQ_IDLE;
                end
            end
            default: state_next = SEQ_IDLE;
        endcase
    end

    // datapath and memory requests per state
    always_comb begin
        func_next       = func_reg;
        start_next      = start_reg;
        need_next       = need_reg;
        cur_next        = cur_reg;
        run_next        = run_reg;
        first_next      = first_reg;
        last_next       = last_reg;
        row_next        = row_reg;
        set_next        = set_reg;
        hint_next       = hint_reg;
        used_next       = used_reg;
        rstat_next      = rstat_reg;
        rgrant_next     = rgrant_reg;
        rused_next      = rused_reg;
        rhint_next      = rhint_reg;
        out_status_next = out_status_reg;
        out_grant_next  = out_grant_reg;
        out_used_next   = out_used_reg;
        out_valid_next  = m_tready ? 1'b0 : out_valid_reg;
        map_rd          = '0;
        map_wr          = '0;
        unique case (state_reg)
            SEQ_IDLE: begin
                if (s_tvalid) begin
                    func_next  = req_func;
                    start_next = req_start;
                    need_next  = req_count;
                end
            end
            SEQ_START: begin
                // default result leaves the state as it is
                rgrant_next = '0;
                rused_next  = used_reg;
                rhint_next  = hint_reg;
                run_next    = '0;
                cur_next    = (hint_wide > reserved) ? hint_wide : reserved;
                if (need_reg == '0) begin
                    rstat_next = STAT_BAD;
                end else if (func_reg == FUNC_ALLOC) begin
                    rstat_next = STAT_NOSPACE;
                end else begin
                    rstat_next = STAT_OK;
                    rused_next = (used_reg > free_cnt) ? (used_reg - free_cnt) : '0;
                    rhint_next = (start_reg < hint_reg) ? start_reg : hint_reg;
                    first_next = start_reg;
                    last_next  = PAGE_W'(free_end - CNT_W'(1));
                    row_next   = start_reg[PAGE_W-1:POS_W];
                    set_next   = 1'b0;
                end
            end
            SEQ_SCAN_RD: begin
                map_rd.en  = !at_limit;
                map_rd.row = cur_reg[PAGE_W-1:POS_W];
            end
            SEQ_SCAN: begin
                if (!at_limit) begin
                    if (seg.hit) begin
                        first_next = PAGE_W'(cur_reg - run_reg);
                    end else begin
                        cur_next = cur_adv;
                        run_next = seg.used ? '0 : (run_reg + CNT_W'(seg.len));
                    end
                end
            end
            SEQ_GRANT: begin
                rstat_next  = STAT_OK;
                rgrant_next = first_reg;
                rhint_next  = alloc_last;
                rused_next  = (alloc_sum > {1'b0, COUNT_MAX}) ? COUNT_MAX : alloc_sum[CNT_W-1:0];
                last_next   = alloc_last;
                row_next    = first_reg[PAGE_W-1:POS_W];
                set_next    = 1'b1;
            end
            SEQ_MOD_RD: begin
                map_rd.en  = 1'b1;
                map_rd.row = row_reg;
            end
            SEQ_MOD_WR: begin
                map_wr.en   = 1'b1;
                map_wr.row  = row_reg;
                map_wr.data = set_reg ? (map_rdata | mod_mask) : (map_rdata & ~mod_mask);
                row_next    = row_reg + ROW_W'(1);
            end
            SEQ_DONE: begin
                // commit counters as the result is loaded into the output register
                if (result_load) begin
                    hint_next       = rhint_reg;
                    used_next       = rused_reg;
                    out_valid_next  = 1'b1;
                    out_status_next = rstat_reg;
                    out_grant_next  = rgrant_reg;
                    out_used_next   = rused_reg;
                end
            end
            default: ;
        endcase
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= SEQ_IDLE;
            hint_reg      <= '0;
            used_reg      <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            hint_reg      <= hint_next;
            used_reg      <= used_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // working and result payload
    always_ff @(posedge aclk) begin
        func_reg       <= func_next;
        start_reg      <= start_next;
        need_reg       <= need_next;
        cur_reg        <= cur_next;
        run_reg        <= run_next;
        first_reg      <= first_next;
        last_reg       <= last_next;
        row_reg        <= row_next;
        set_reg        <= set_next;
        rstat_reg      <= rstat_next;
        rgrant_reg     <= rgrant_next;
        rused_reg      <= rused_next;
        rhint_reg      <= rhint_next;
        out_status_reg <= out_status_next;
        out_grant_reg  <= out_grant_next;
        out_used_reg   <= out_used_next;
    end

    assign s_tready    = state_reg == SEQ_IDLE;
    assign m_tvalid    = out_valid_reg;
    assign res_status  = out_status_reg;
    assign res_granted = out_grant_reg;
    assign res_used    = out_used_reg;

    // the run being built never reaches the request size without a hit
    a_run_below_need: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == SEQ_SCAN) |-> (run_reg < need_reg))
        else $error("scan run reached request size without a grant");

    // a new result only comes out of the done state
    a_result_from_done: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(out_valid_reg) |-> $past(state_reg == SEQ_DONE))
        else $error("result transfer raised outside done state");

    // a nonzero granted page only goes with a successful request
    a_grant_only_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && (out_grant_reg != '0)) |-> (out_status_reg == STAT_OK))
        else $error("granted page set on a failed request");

    // scan steps always follow a row read or an earlier scan step
    a_scan_has_row: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == SEQ_SCAN) |-> $past(state_reg == SEQ_SCAN_RD || state_reg == SEQ_SCAN))
        else $error("scan step without a row read");

endmodule

`default_nettype wire

/* hdl/bitmap_page_frame_allocator_unit.sv */
// top level of the bitmap page frame allocator: configuration registers, stream ports
`timescale 1ns / 1ps
`default_nettype none

// First-fit page frame allocator over a 4096-page bitmap held as 64 rows of 64 bits.
// Each request gives exactly one result; the block takes one request at a time and
// s_tready is high only when idle. An allocate walks upward from the search hint (or the
// reserved count if higher) with one shared shift and trailing-zero unit: each row is read
// and then scanned one stretch of equal bits per step, and the found run is marked in a
// grant step and then with a read and a write of each row it touches, between a setup
// step and a result step. A free clears its clipped range with a read and a write per row
// touched; a zero-count request goes from setup straight to the result. The bitmap reads
// as all free after reset with no clearing pass. The result sits in an output register,
// so the next request can start while it waits.
module bitmap_page_frame_allocator_unit (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // configuration write port
    input  wire logic        cfg_wr_en,
    input  wire logic        cfg_wr_index,
    input  wire logic [12:0] cfg_wr_data,
    // request stream
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,  // [11:0] start_page, [24:12] page_count, rest zero
    input  wire logic        s_tuser,  // [0] func
    // result stream
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata,  // [11:0] granted_page, [24:12] used_pages, rest zero
    output logic [1:0]       m_tuser   // [1:0] status
);
    import bpfa_pkg::*;

    logic [CNT_W-1:0]  managed_reg;
    logic [CNT_W-1:0]  reserved_reg;
    logic [CNT_W-1:0]  limit;
    map_rd_t           map_rd;
    map_wr_t           map_wr;
    word_t             map_rdata;
    logic [PAGE_W-1:0] granted;
    logic [CNT_W-1:0]  used;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            managed_reg  <= PAGE_LIMIT;
            reserved_reg <= RESERVED_INIT;
        end else if (cfg_wr_en) begin
            unique case (cfg_wr_index)
                REG_MANAGED:  managed_reg  <= cfg_wr_data;
                REG_RESERVED: reserved_reg <= cfg_wr_data;
                default: ;
            endcase
        end
    end

    // managed count clipped to the bitmap size
    assign limit = (managed_reg > PAGE_LIMIT) ? PAGE_LIMIT : managed_reg;

    bpfa_map u_map (
        .aclk    (aclk),
        .aresetn (aresetn),
        .rd      (map_rd),
        .rdata   (map_rdata),
        .wr      (map_wr)
    );

    bpfa_seq u_seq (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .req_func    (s_tuser),
        .req_start   (s_tdata[11:0]),
        .req_count   (s_tdata[24:12]),
        .limit       (limit),
        .reserved    (reserved_reg),
        .map_rd      (map_rd),
        .map_rdata   (map_rdata),
        .map_wr      (map_wr),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .res_status  (m_tuser),
        .res_granted (granted),
        .res_used    (used)
    );

    // result packing
    assign m_tdata = {7'd0, used, granted};

endmodule

`default_nettype wire

/* bench/bpfa_checker.sv */
// checker for the page frame allocator: watches both streams, predicts results and compares
`timescale 1ns / 1ps

module bpfa_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic        cfg_wr_index,
    input  logic [12:0] cfg_wr_data,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [31:0] s_tdata,    // [11:0] start_page, [24:12] page_count
    input  logic        s_tuser,    // [0] func
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [31:0] m_tdata,    // [11:0] granted_page, [24:12] used_pages
    input  logic [1:0]  m_tuser,    // [1:0] status
    output int          mismatches,
    output int          outstanding,
    output int          ok_seen,
    output int          nospace_seen,
    output int          bad_seen
);
    import bpfa_pkg::*;

    typedef struct {
        bpfa_status_t      status;
        logic [PAGE_W-1:0] granted;
        logic [CNT_W-1:0]  used;
    } page_result_t;

    // shadow copy of the allocator state and registers
    logic              page_used [MAX_PAGES];
    logic [PAGE_W-1:0] search_hint;
    logic [CNT_W-1:0]  used_count;
    logic [CNT_W-1:0]  managed_pages;
    logic [CNT_W-1:0]  reserved_pages;

    page_result_t pending_results [$];

    initial begin
        mismatches   = 0;
        outstanding  = 0;
        ok_seen      = 0;
        nospace_seen = 0;
        bad_seen     = 0;
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("%0t mismatch: %s got %0d expected %0d", $time, what, got, want);
        mismatches++;
    endtask

    task automatic clear_allocator();
        for (int p = 0; p < MAX_PAGES; p++) begin
            page_used[p] = 1'b0;
        end
        search_hint    = '0;
        used_count     = '0;
        managed_pages  = PAGE_LIMIT;
        reserved_pages = RESERVED_INIT;
    endtask

    // first-fit allocate or clipped free, one result per request
    task automatic serve_request(input logic func, input logic [PAGE_W-1:0] start,
                                 input logic [CNT_W-1:0] n, output page_result_t res);
        int span, pos, run, first, stop, total;
        res.status  = STAT_OK;
        res.granted = '0;
        span = (int'(managed_pages) > MAX_PAGES) ? MAX_PAGES : int'(managed_pages);
        if (n == '0) begin
            res.status = STAT_BAD;
        end else if (func == FUNC_ALLOC) begin
            res.status = STAT_NOSPACE;
            run = 0;
            pos = (search_hint > reserved_pages) ? int'(search_hint) : int'(reserved_pages);
            while (pos < span && res.status == STAT_NOSPACE) begin
                if (page_used[pos]) begin
                    run = 0;
                end else begin
                    run++;
                    if (run == int'(n)) begin
                        first = pos - int'(n) + 1;
                        for (int p = first; p <= pos; p++) begin
                            page_used[p] = 1'b1;
                        end
                        total = int'(used_count) + int'(n);
                        used_count  = (total > int'(COUNT_MAX)) ? COUNT_MAX : CNT_W'(total);
                        search_hint = PAGE_W'(pos);
                        res.granted = PAGE_W'(first);
                        res.status  = STAT_OK;
                    end
                end
                pos++;
            end
        end else begin
            stop = int'(start) + int'(n);
            if (stop > span) begin
                stop = span;
            end
            // every page in the clipped range lowers the count, used or not
            for (int p = int'(start); p < stop; p++) begin
                page_used[p] = 1'b0;
                if (used_count != '0) begin
                    used_count = used_count - 1'b1;
                end
            end
            if (start < search_hint) begin
                search_hint = start;
            end
        end
        res.used = used_count;
    endtask

    // results first, since a result can never belong to a request taken on the same edge
    always @(posedge aclk) begin : watch
        page_result_t want;
        page_result_t fresh;
        if (!aresetn) begin
            clear_allocator();
            pending_results.delete();
        end else begin
            if (m_tvalid && m_tready) begin
                if (pending_results.size() == 0) begin
                    report_mismatch("result transfer with nothing pending, status", m_tuser, 0);
                end else begin
                    want = pending_results.pop_front();
                    if (m_tuser !== want.status) begin
                        report_mismatch("status", m_tuser, want.status);
                    end
                    if (m_tdata[PAGE_W-1:0] !== want.granted) begin
                        report_mismatch("granted_page", m_tdata[PAGE_W-1:0], want.granted);
                    end
                    if (m_tdata[PAGE_W+CNT_W-1:PAGE_W] !== want.used) begin
                        report_mismatch("used_pages", m_tdata[PAGE_W+CNT_W-1:PAGE_W],
                                        want.used);
                    end
                    case (want.status)
                        STAT_OK:      ok_seen++;
                        STAT_NOSPACE: nospace_seen++;
                        default:      bad_seen++;
                    endcase
                end
            end
            if (cfg_wr_en) begin
                case (cfg_wr_index)
                    REG_MANAGED:  managed_pages  = cfg_wr_data;
                    REG_RESERVED: reserved_pages = cfg_wr_data;
                endcase
            end
            if (s_tvalid && s_tready) begin
                serve_request(s_tuser, s_tdata[PAGE_W-1:0], s_tdata[PAGE_W+CNT_W-1:PAGE_W],
                              fresh);
                pending_results.push_back(fresh);
            end
        end
        outstanding <= pending_results.size();
    end

endmodule

/* bench/tb_top.sv */
// top of the page frame allocator bench: clock, reset, request and result traffic, verdict
`timescale 1ns / 1ps

module tb_top;
    import bpfa_pkg::*;

    localparam int HOLD_CYCLES = 600;
    localparam int CYCLE_LIMIT = 40_000_000;
    localparam int CFG_SETTLE  = 16;
    localparam int END_SETTLE  = 200;

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        cfg_wr_en;
    logic        cfg_wr_index;
    logic [12:0] cfg_wr_data;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;
    logic        s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;
    logic [1:0]  m_tuser;

    int mismatches, outstanding, ok_seen, nospace_seen, bad_seen;
    int cycle_count = 0;
    int requests_sent = 0;
    int settings_used = 0;
    bit steady = 1'b0;
    bit hold_off_req = 1'b0;

    // allocate counts of requests in flight, and runs currently granted
    int                alloc_len_q [$];
    logic [PAGE_W-1:0] live_start_q [$];
    int                live_len_q [$];

    always #5 aclk = ~aclk;

    bitmap_page_frame_allocator_unit dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_index (cfg_wr_index),
        .cfg_wr_data  (cfg_wr_data),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .s_tuser      (s_tuser),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .m_tuser      (m_tuser)
    );

    bpfa_checker u_checker (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_index (cfg_wr_index),
        .cfg_wr_data  (cfg_wr_data),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .s_tuser      (s_tuser),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .m_tuser      (m_tuser),
        .mismatches   (mismatches),
        .outstanding  (outstanding),
        .ok_seen      (ok_seen),
        .nospace_seen (nospace_seen),
        .bad_seen     (bad_seen)
    );

    // run guard
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results still pending",
                     cycle_count, outstanding);
            $display("DONE: errors detected");
            $finish;
        end
    end

    // idle length: mostly none or short, now and then long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (steady || r < 55) begin
            return 0;
        end
        if (r < 88) begin
            return $urandom_range(1, 3);
        end
        if (r < 97) begin
            return $urandom_range(4, 15);
        end
        return $urandom_range(30, 150);
    endfunction

    function automatic logic [CNT_W-1:0] alloc_size();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) begin
            return CNT_W'($urandom_range(1, 8));
        end
        if (r < 90) begin
            return CNT_W'($urandom_range(9, 64));
        end
        if (r < 97) begin
            return CNT_W'($urandom_range(65, 600));
        end
        return CNT_W'($urandom_range(1, 8191));
    endfunction

    // remember granted runs so that later frees hit real allocations
    always @(posedge aclk) begin : grant_tracker
        int n;
        if (aresetn && m_tvalid && m_tready && alloc_len_q.size() > 0) begin
            n = alloc_len_q.pop_front();
            if (m_tuser == STAT_OK && n != 0) begin
                live_start_q.push_back(m_tdata[PAGE_W-1:0]);
                live_len_q.push_back(n);
            end
        end
    end

    // result side: random stalls plus one long hold-off on request
    initial begin : result_sink
        int gap, burst;
        m_tready = 1'b0;
        while (aresetn !== 1'b1) @(posedge aclk);
        forever begin
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                repeat (HOLD_CYCLES) begin
                    @(posedge aclk);
                    m_tready <= 1'b0;
                end
            end
            gap   = pick_gap();
            burst = $urandom_range(1, 12);
            repeat (gap) begin
                @(posedge aclk);
                m_tready <= 1'b0;
            end
            repeat (burst) begin
                @(posedge aclk);
                m_tready <= 1'b1;
            end
        end
    end

    // one request transfer; valid stays high when the next one follows with no gap
    task automatic send_request(input logic func, input logic [PAGE_W-1:0] start,
                                input logic [CNT_W-1:0] n);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {7'd0, n, start};
        s_tuser  <= func;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        alloc_len_q.push_back((func == FUNC_ALLOC) ? int'(n) : 0);
        requests_sent++;
    endtask

    // stop offering and wait for every pending result
    task automatic drain_results(input int settle);
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (outstanding != 0) @(posedge aclk);
        repeat (settle) @(posedge aclk);
    endtask

    task automatic write_register(input logic idx, input logic [12:0] value);
        @(posedge aclk);
        cfg_wr_en    <= 1'b1;
        cfg_wr_index <= idx;
        cfg_wr_data  <= value;
        @(posedge aclk);
        cfg_wr_en    <= 1'b0;
    endtask

    task automatic apply_setting(input int managed, input int reserved);
        drain_results(CFG_SETTLE);
        write_register(REG_MANAGED, 13'(managed));
        write_register(REG_RESERVED, 13'(reserved));
        settings_used++;
    endtask

    // mostly allocate and free of granted runs, plus stray frees and zero counts
    task automatic send_random(input int span);
        int r, idx, len, top_page;
        logic [PAGE_W-1:0] start;
        logic [CNT_W-1:0]  n;
        r = $urandom_range(0, 99);
        top_page = (span + 16 > 4095) ? 4095 : span + 16;
        if (r < 50) begin
            send_request(FUNC_ALLOC, PAGE_W'($urandom), alloc_size());
        end else if (r < 80 && live_start_q.size() > 0) begin
            idx   = $urandom_range(0, live_start_q.size() - 1);
            start = live_start_q[idx];
            len   = live_len_q[idx];
            live_start_q.delete(idx);
            live_len_q.delete(idx);
            if ($urandom_range(0, 9) == 0) begin
                len = $urandom_range(1, len);
            end
            send_request(FUNC_FREE, start, CNT_W'(len));
        end else if (r < 94) begin
            start = $urandom_range(0, 1) ? PAGE_W'($urandom)
                                         : PAGE_W'($urandom_range(0, top_page));
            n = ($urandom_range(0, 4) == 0) ? CNT_W'($urandom)
                                            : CNT_W'($urandom_range(1, 32));
            send_request(FUNC_FREE, start, n);
        end else begin
            send_request(1'($urandom), PAGE_W'($urandom), '0);
        end
    endtask

    // register settings for the random phases, extremes included
    task automatic pick_setting(input int ph, output int managed, output int reserved,
                                output int items);
        case (ph)
            0:       begin managed = 4096; reserved = 8;    items = 400; end
            1:       begin managed = 256;  reserved = 16;   items = 300; end
            2:       begin managed = 8191; reserved = 0;    items = 250; end
            3:       begin managed = 96;   reserved = 90;   items = 150; end
            4:       begin managed = 0;    reserved = 0;    items = 60;  end
            5:       begin managed = 4096; reserved = 4096; items = 60;  end
            6:       begin managed = 1000; reserved = 8191; items = 60;  end
            default: begin managed = 512;  reserved = 0;    items = 370; end
        endcase
    endtask

    initial begin : stimulus
        int managed, reserved, items;
        aresetn      = 1'b0;
        cfg_wr_en    = 1'b0;
        cfg_wr_index = 1'b0;
        cfg_wr_data  = '0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        s_tuser      = 1'b0;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: zero counts, full map, free past the end, count saturating at zero
        send_request(FUNC_ALLOC, 12'd0,    13'd0);
        send_request(FUNC_FREE,  12'hfff,  13'd0);
        send_request(FUNC_ALLOC, 12'd0,    13'd1);
        send_request(FUNC_ALLOC, 12'd0,    13'd4096);
        send_request(FUNC_ALLOC, 12'hfff,  13'h1fff);
        send_request(FUNC_ALLOC, 12'd0,    13'd4087);
        send_request(FUNC_ALLOC, 12'd0,    13'd1);
        send_request(FUNC_FREE,  12'hfff,  13'h1fff);
        send_request(FUNC_ALLOC, 12'd0,    13'd1);
        send_request(FUNC_FREE,  12'd0,    13'd4096);
        send_request(FUNC_FREE,  12'd4095, 13'd1);
        send_request(FUNC_ALLOC, 12'd0,    13'd64);

        // managed count above the bitmap, reserved at the limit
        apply_setting(8191, 4096);
        send_request(FUNC_ALLOC, 12'd0,   13'd1);
        send_request(FUNC_FREE,  12'd100, 13'd1);

        // nothing managed: allocate fails, frees clear nothing
        apply_setting(0, 0);
        send_request(FUNC_ALLOC, 12'd0,    13'd1);
        send_request(FUNC_FREE,  12'd0,    13'd5);
        send_request(FUNC_FREE,  12'd4000, 13'd10);

        // random phases
        for (int ph = 0; ph < 8; ph++) begin
            pick_setting(ph, managed, reserved, items);
            apply_setting(managed, reserved);
            for (int k = 0; k < items; k++) begin
                if (k % 100 == 0) begin
                    steady = ($urandom_range(0, 3) == 0);
                end
                // long result stall while requests keep coming
                if (ph == 1 && k == 40) begin
                    steady       = 1'b1;
                    hold_off_req = 1'b1;
                end
                send_random(managed);
            end
        end

        drain_results(END_SETTLE);
        $display("run: %0d requests over %0d register settings, one %0d-cycle result stall",
                 requests_sent, settings_used, HOLD_CYCLES);
        $display("outcomes: %0d ok, %0d no free run, %0d bad request",
                 ok_seen, nospace_seen, bad_seen);
        if (mismatches == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

/* files.f */
hdl/bpfa_pkg.sv
hdl/bpfa_map.sv
hdl/bpfa_seg.sv
hdl/bpfa_seq.sv
hdl/bitmap_page_frame_allocator_unit.sv
bench/bpfa_checker.sv
bench/tb_top.sv
